// ===== rtl/quicksort_engine_with_op_counts_unit_defines.svh =====
// Assertion macros shared by the sort engine.
`ifndef QUICKSORT_ENGINE_WITH_OP_COUNTS_UNIT_DEFINES_SVH
`define QUICKSORT_ENGINE_WITH_OP_COUNTS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qsort_pkg.sv =====
`default_nettype none
package qsort_pkg;

  // Width of the operation counters.
  localparam int CNT_W = 20;
  localparam int VAL_W = 32;
  localparam logic [2:0] INC_ONE  = 3'd1;
  localparam logic [2:0] INC_SWAP = 3'd4;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_PUSH0, S_POP, S_RANGE, S_MID, S_PIV,
    S_LRD, S_LCHK, S_HRD, S_HCHK, S_DECIDE, S_SWL, S_SWH,
    S_PUSHR, S_PUSHL, S_ORD, S_OLD, S_OWAIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;
    logic init;
    logic push_full;
    logic pop;
    logic range_ld;
    logic rd_mid;
    logic piv_ld;
    logic rd_l;
    logic scan_l;
    logic rd_h;
    logic h_zero_cnt;
    logic scan_h;
    logic swap_l;
    logic swap_h;
    logic push_right;
    logic push_left;
    logic rd_out;
    logic out_ld;
    logic out_next;
    logic run_end;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_lt2;
    logic sp_zero;
    logic l_lt_piv;
    logic piv_lt_h;
    logic h_zero;
    logic l_ge_h;
    logic out_is_last;
    logic full;
    logic dropped;
  } sts_t;

  // Add a small increment to a counter, sticking at the top value.
  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] c, logic [2:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, c} + {{(CNT_W-2){1'b0}}, n};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qsort_ram.sv =====
`default_nettype none
module qsort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/qsort_ctrl.sv =====
`default_nettype none
module qsort_ctrl
  import qsort_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_last,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (in_last) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = sts.fill_lt2 ? S_ORD : S_PUSH0;
      end
      S_PUSH0: begin
        cmd.push_full = 1'b1;
        state_nxt     = S_POP;
      end
      S_POP: begin
        if (sts.sp_zero) begin
          state_nxt = S_ORD;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        cmd.range_ld = 1'b1;
        state_nxt    = S_MID;
      end
      S_MID: begin
        cmd.rd_mid = 1'b1;
        state_nxt  = S_PIV;
      end
      S_PIV: begin
        cmd.piv_ld = 1'b1;
        state_nxt  = S_LRD;
      end
      S_LRD: begin
        cmd.rd_l  = 1'b1;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        cmd.scan_l = 1'b1;
        state_nxt  = sts.l_lt_piv ? S_LRD : S_HRD;
      end
      S_HRD: begin
        if (sts.h_zero) begin
          cmd.h_zero_cnt = 1'b1;
          state_nxt      = S_DECIDE;
        end else begin
          cmd.rd_h  = 1'b1;
          state_nxt = S_HCHK;
        end
      end
      S_HCHK: begin
        cmd.scan_h = 1'b1;
        state_nxt  = sts.piv_lt_h ? S_HRD : S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = sts.l_ge_h ? S_PUSHR : S_SWL;
      end
      S_SWL: begin
        cmd.swap_l = 1'b1;
        state_nxt  = S_SWH;
      end
      S_SWH: begin
        cmd.swap_h = 1'b1;
        state_nxt  = S_LRD;
      end
      S_PUSHR: begin
        cmd.push_right = 1'b1;
        state_nxt      = S_PUSHL;
      end
      S_PUSHL: begin
        cmd.push_left = 1'b1;
        state_nxt     = S_POP;
      end
      S_ORD: begin
        cmd.rd_out = 1'b1;
        state_nxt  = S_OLD;
      end
      S_OLD: begin
        cmd.out_ld = 1'b1;
        state_nxt  = S_OWAIT;
      end
      S_OWAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.out_is_last) begin
            cmd.run_end = 1'b1;
            state_nxt   = S_LOAD;
          end else begin
            cmd.out_next = 1'b1;
            state_nxt    = S_ORD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/qsort_dp.sv =====
`default_nettype none
module qsort_dp
  import qsort_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire logic [VAL_W-1:0] in_value,
  output logic      [VAL_W-1:0] out_value,
  output logic                  out_last,
  output logic      [CNT_W-1:0] out_cmp,
  output logic      [CNT_W-1:0] out_acc,
  output logic                  out_ovf
);

  localparam int AW  = $clog2(MAX_ELEMENTS);
  localparam int SPW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [SPW-1:0] FULL = SPW'(MAX_ELEMENTS);

  logic [SPW-1:0]   fill_r, sp_r;
  logic             drop_r;
  logic [CNT_W-1:0] cmp_r, acc_r;
  logic [AW-1:0]    lo_r, hi_r, l_r, h_r, idx_r;
  logic [VAL_W-1:0] piv_r, val_l_r, val_h_r;

  logic             e_we, s_we;
  logic [AW-1:0]    e_waddr, e_raddr, s_waddr, s_raddr, mid;
  logic [VAL_W-1:0] e_wdata, e_rdata;
  logic [2*AW-1:0]  s_wdata, s_rdata;
  logic [AW:0]      h_inc;
  logic             push_r_ok, push_l_ok, sp_room;

  qsort_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  qsort_ram #(.WIDTH(2*AW), .DEPTH(MAX_ELEMENTS)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // Element store addressing.
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign e_we    = (cmd.load_wr && !sts.full) || cmd.swap_l || cmd.swap_h;
  assign e_waddr = cmd.load_wr ? fill_r[AW-1:0] : (cmd.swap_l ? l_r : h_r);
  assign e_wdata = cmd.load_wr ? in_value : (cmd.swap_l ? val_h_r : val_l_r);

  always_comb begin
    if (cmd.rd_mid) begin
      e_raddr = mid;
    end else if (cmd.rd_l) begin
      e_raddr = l_r;
    end else if (cmd.rd_h) begin
      e_raddr = h_r;
    end else begin
      e_raddr = idx_r;
    end
  end

  // Range stack: push the sub-ranges that still hold two or more entries.
  assign h_inc     = {1'b0, h_r} + {{AW{1'b0}}, 1'b1};
  assign sp_room   = sp_r < FULL;
  assign push_r_ok = cmd.push_right && (h_inc < {1'b0, hi_r}) && sp_room;
  assign push_l_ok = cmd.push_left && (lo_r < h_r) && sp_room;
  assign s_we      = cmd.push_full || push_r_ok || push_l_ok;
  assign s_waddr   = sp_r[AW-1:0];
  assign s_raddr   = AW'(sp_r - SPW'(1));

  always_comb begin
    if (cmd.push_full) begin
      s_wdata = {{AW{1'b0}}, AW'(fill_r - SPW'(1))};
    end else if (cmd.push_right) begin
      s_wdata = {h_inc[AW-1:0], hi_r};
    end else begin
      s_wdata = {lo_r, h_r};
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.fill_lt2    = fill_r < SPW'(2);
    sts.sp_zero     = sp_r == '0;
    sts.l_lt_piv    = $signed(e_rdata) < $signed(piv_r);
    sts.piv_lt_h    = $signed(piv_r) < $signed(e_rdata);
    sts.h_zero      = h_r == '0;
    sts.l_ge_h      = l_r >= h_r;
    sts.out_is_last = out_last;
    sts.full        = fill_r == FULL;
    sts.dropped     = drop_r;
  end

  // Control registers: fill level, stack pointer, counters and flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sp_r   <= '0;
      drop_r <= 1'b0;
      cmp_r  <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.load_wr) begin
        if (sts.full) drop_r <= 1'b1;
        else          fill_r <= fill_r + SPW'(1);
      end
      if (cmd.init) begin
        sp_r  <= '0;
        cmp_r <= '0;
        acc_r <= '0;
      end
      if (s_we) sp_r <= sp_r + SPW'(1);
      if (cmd.pop) sp_r <= sp_r - SPW'(1);
      if (cmd.rd_mid) acc_r <= sat_add(acc_r, INC_ONE);
      if (cmd.scan_l || cmd.scan_h || cmd.h_zero_cnt) begin
        cmp_r <= sat_add(cmp_r, INC_ONE);
        acc_r <= sat_add(acc_r, INC_ONE);
      end
      if (cmd.swap_l) acc_r <= sat_add(acc_r, INC_SWAP);
      if (cmd.run_end) begin
        fill_r <= '0;
        drop_r <= 1'b0;
        sp_r   <= '0;
      end
    end
  end

  // Partition indices, pivot, scan values and the output register.
  always_ff @(posedge clk) begin
    if (cmd.init) idx_r <= '0;
    if (cmd.out_next) idx_r <= idx_r + AW'(1);
    if (cmd.range_ld) begin
      lo_r <= s_rdata[2*AW-1:AW];
      hi_r <= s_rdata[AW-1:0];
      l_r  <= s_rdata[2*AW-1:AW];
      h_r  <= s_rdata[AW-1:0];
    end
    if (cmd.piv_ld) piv_r <= e_rdata;
    if (cmd.scan_l) begin
      if (sts.l_lt_piv) l_r <= l_r + AW'(1);
      else              val_l_r <= e_rdata;
    end
    if (cmd.scan_h) begin
      if (sts.piv_lt_h) h_r <= h_r - AW'(1);
      else              val_h_r <= e_rdata;
    end
    if (cmd.swap_h) begin
      l_r <= l_r + AW'(1);
      h_r <= h_r - AW'(1);
    end
    if (cmd.out_ld) begin
      out_value <= e_rdata;
      out_last  <= SPW'(idx_r) == (fill_r - SPW'(1));
      out_cmp   <= cmp_r;
      out_acc   <= acc_r;
      out_ovf   <= drop_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/quicksort_engine_with_op_counts_unit.sv =====
// Loading: one input request per cycle; the sort starts after the request marked last.
// Sorting: each scan test reads the registered element memory and then compares; each
// partition round ends in a decision step, each swap writes the low and then the high
// entry, and each popped range is loaded and its middle element read as the pivot.
// Output: each result takes a memory read, an output load and then a handshake.
// Reset (rst_n low, synchronous) empties the store, clears counters and the overflow flag.
`default_nettype none
module quicksort_engine_with_op_counts_unit
  import qsort_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [71:0] out_tdata,  // sorted_value[31:0], compare_count[51:32],
                                       // access_count[71:52]
  output logic             out_tlast,  // last_out
  output logic             out_tuser   // overflow
);

  `include "quicksort_engine_with_op_counts_unit_defines.svh"

  cmd_t             cmd;
  sts_t             sts;
  logic [VAL_W-1:0] sorted_value;
  logic [CNT_W-1:0] compare_count, access_count;

  qsort_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_last(in_tlast), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .sts(sts), .cmd(cmd)
  );

  qsort_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_value(in_tdata),
    .out_value(sorted_value), .out_last(out_tlast),
    .out_cmp(compare_count), .out_acc(access_count), .out_ovf(out_tuser)
  );

  // Pack the result fields.
  assign out_tdata = {access_count, compare_count, sorted_value};

  // Loading and emitting never overlap.
  `QS_ASSERT_NOW(a_no_overlap, in_tready, !out_tvalid, "input taken while emitting")
  // After the final result the block goes back to loading.
  `QS_ASSERT_NEXT(a_back_to_load, out_tvalid && out_tready && out_tlast, in_tready,
    "block did not return to loading")
  // A request that arrives with the store full sets the drop flag.
  `QS_ASSERT_NEXT(a_drop_flag, in_tvalid && in_tready && sts.full && !in_tlast, sts.dropped,
    "drop flag not set on full store")

endmodule
`default_nettype wire
